// File: design/gregorian_date_step_and_check_defines.svh
// Assertion macros for the Gregorian date step and check block.
// Included by the top level; depends on a clock i_clk and reset i_rst_n in scope.
`ifndef GREGORIAN_DATE_STEP_AND_CHECK_DEFINES_SVH
`define GREGORIAN_DATE_STEP_AND_CHECK_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low.
`define GDSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gdsc same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define GDSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gdsc next-cycle check failed");

`else

`define GDSC_ASSERT_SAME(label, ante, cons)
`define GDSC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: design/gdsc_pkg.sv
// Shared constants and helper functions for the Gregorian date step and check block.
// No dependencies.
package gdsc_pkg;

    // Month numbers that the calendar logic tests by name.
    localparam logic [3:0] M_JAN = 4'd1;
    localparam logic [3:0] M_FEB = 4'd2;
    localparam logic [3:0] M_MAR = 4'd3;
    localparam logic [3:0] M_APR = 4'd4;
    localparam logic [3:0] M_MAY = 4'd5;
    localparam logic [3:0] M_JUN = 4'd6;
    localparam logic [3:0] M_JUL = 4'd7;
    localparam logic [3:0] M_AUG = 4'd8;
    localparam logic [3:0] M_SEP = 4'd9;
    localparam logic [3:0] M_OCT = 4'd10;
    localparam logic [3:0] M_NOV = 4'd11;
    localparam logic [3:0] M_DEC = 4'd12;

    // Month lengths.
    localparam logic [4:0] DAYS_28 = 5'd28;
    localparam logic [4:0] DAYS_29 = 5'd29;
    localparam logic [4:0] DAYS_30 = 5'd30;
    localparam logic [4:0] DAYS_31 = 5'd31;

    // Largest year accepted as a valid date.
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    // Division by 25 as a multiply by a rounded-up reciprocal; exact for all 14-bit years.
    localparam int          DIV25_SHIFT = 19;
    localparam logic [14:0] DIV25_MUL   = 15'((2 ** DIV25_SHIFT + 24) / 25);

    // Length of a month; months outside 1 to 12 read as 31 and are masked later.
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            M_APR, M_JUN, M_SEP, M_NOV: len = DAYS_30;
            M_FEB:                      len = leap ? DAYS_29 : DAYS_28;
            default:                    len = DAYS_31;
        endcase
        return len;
    endfunction

    // Quarter of a month 1 to 12; other codes give zero.
    function automatic logic [2:0] quarter_of(input logic [3:0] month);
        logic [2:0] q;
        case (month)
            M_JAN, M_FEB, M_MAR: q = 3'd1;
            M_APR, M_MAY, M_JUN: q = 3'd2;
            M_JUL, M_AUG, M_SEP: q = 3'd3;
            M_OCT, M_NOV, M_DEC: q = 3'd4;
            default:             q = 3'd0;
        endcase
        return q;
    endfunction

endpackage

// File: design/gregorian_date_step_and_check.sv
// Gregorian date step and check: validity, quarter, month length, next and previous date.
// Depends on gdsc_pkg and gregorian_date_step_and_check_defines.svh.
//
// Each input item is one date; each yields exactly one result item, and while the input
// is not stalled a new date is accepted on every cycle. The three register stages are a
// divide-by-25 reciprocal multiply for the leap-year test, the leap year and month lengths,
// and the next/previous step, whose registers also serve as the output register. Every
// stage holds its own valid bit, so backpressure fills bubbles before it reaches the input.
// An invalid date (day 0, month 0 or above 12, year above 9999, or day past month end)
// gives a result with valid_res low and every data field zero.
`include "gregorian_date_step_and_check_defines.svh"

module gregorian_date_step_and_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input date items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // day[4:0], month[8:5], year[22:9], zero[23]
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // quarter[2:0], month_days[7:3], next_day[12:8], next_month[16:13],
    // next_year[30:17], prev_day[35:31], prev_month[39:36], prev_year[54:40], zero[55]
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tuser   // valid_res[0]
);

    // Stage valid bits and per-stage ready.
    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    assign rdy3          = !r_v3 || m_axis_tready;
    assign rdy2          = !r_v2 || rdy3;
    assign rdy1          = !r_v1 || rdy2;
    assign s_axis_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage 1: unpack, range checks, and the reciprocal multiply for year / 25.
    logic [4:0]  in_day;
    logic [3:0]  in_month;
    logic [13:0] in_year;
    logic [28:0] n1_prod;
    logic        n1_range_ok;

    assign in_day      = s_axis_tdata[4:0];
    assign in_month    = s_axis_tdata[8:5];
    assign in_year     = s_axis_tdata[22:9];
    assign n1_prod     = {15'd0, in_year} * {14'd0, gdsc_pkg::DIV25_MUL};
    assign n1_range_ok = (in_day != 5'd0) && (in_month != 4'd0)
                      && (in_month <= gdsc_pkg::M_DEC) && (in_year <= gdsc_pkg::YEAR_MAX);

    logic [4:0]  r_s1_day;
    logic [3:0]  r_s1_month;
    logic [13:0] r_s1_year;
    logic [9:0]  r_s1_q25;
    logic        r_s1_range_ok;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_day      <= in_day;
            r_s1_month    <= in_month;
            r_s1_year     <= in_year;
            r_s1_q25      <= n1_prod[gdsc_pkg::DIV25_SHIFT +: 10];
            r_s1_range_ok <= n1_range_ok;
        end
    end

    // Stage 2: leap year by the 4/100/400 rule, both month lengths, the quarter, and validity.
    logic [14:0] n2_q25x25;
    logic [14:0] n2_rem25;
    logic        n2_div25;
    logic        n2_leap;
    logic [3:0]  n2_prev_month;
    logic [4:0]  n2_len;
    logic [4:0]  n2_plen;

    assign n2_q25x25     = {1'b0, r_s1_q25, 4'd0} + {2'b0, r_s1_q25, 3'd0} + {5'd0, r_s1_q25};
    assign n2_rem25      = {1'b0, r_s1_year} - n2_q25x25;
    assign n2_div25      = (n2_rem25 == 15'd0);
    // Divisible by 100 means by 4 and 25; by 400 means by 16 and 25.
    assign n2_leap       = ((r_s1_year[1:0] == 2'd0) && !n2_div25)
                        || ((r_s1_year[3:0] == 4'd0) && n2_div25);
    assign n2_prev_month = (r_s1_month == gdsc_pkg::M_JAN) ? gdsc_pkg::M_DEC
                                                           : r_s1_month - 4'd1;
    assign n2_len        = gdsc_pkg::days_in(r_s1_month, n2_leap);
    assign n2_plen       = gdsc_pkg::days_in(n2_prev_month, n2_leap);

    logic [4:0]  r_s2_day;
    logic [3:0]  r_s2_month;
    logic [13:0] r_s2_year;
    logic [4:0]  r_s2_len;
    logic [4:0]  r_s2_plen;
    logic [2:0]  r_s2_quarter;
    logic        r_s2_valid;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_day     <= r_s1_day;
            r_s2_month   <= r_s1_month;
            r_s2_year    <= r_s1_year;
            r_s2_len     <= n2_len;
            r_s2_plen    <= n2_plen;
            r_s2_quarter <= gdsc_pkg::quarter_of(r_s1_month);
            r_s2_valid   <= r_s1_range_ok && (r_s1_day <= n2_len);
        end
    end

    // Stage 3: step forward and back one day, zero everything for an invalid date.
    logic [4:0]  n3_next_day, n3_prev_day;
    logic [3:0]  n3_next_month, n3_prev_month;
    logic [13:0] n3_next_year;
    logic [14:0] n3_prev_year;

    always_comb begin
        n3_next_day   = r_s2_day + 5'd1;
        n3_next_month = r_s2_month;
        n3_next_year  = r_s2_year;
        if (r_s2_day >= r_s2_len) begin
            n3_next_day = 5'd1;
            if (r_s2_month == gdsc_pkg::M_DEC) begin
                n3_next_month = gdsc_pkg::M_JAN;
                n3_next_year  = r_s2_year + 14'd1;
            end else begin
                n3_next_month = r_s2_month + 4'd1;
            end
        end

        n3_prev_day   = r_s2_day - 5'd1;
        n3_prev_month = r_s2_month;
        n3_prev_year  = {1'b0, r_s2_year};
        if (r_s2_day <= 5'd1) begin
            if (r_s2_month == gdsc_pkg::M_JAN) begin
                // New Year's Day steps back to the last day of the year before.
                n3_prev_day   = gdsc_pkg::DAYS_31;
                n3_prev_month = gdsc_pkg::M_DEC;
                n3_prev_year  = {1'b0, r_s2_year} - 15'd1;
            end else begin
                n3_prev_day   = r_s2_plen;
                n3_prev_month = r_s2_month - 4'd1;
            end
        end
    end

    logic [55:0] r_s3_data;
    logic        r_s3_valid_res;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_valid_res <= r_s2_valid;
            if (r_s2_valid) begin
                r_s3_data <= {1'b0, n3_prev_year, n3_prev_month, n3_prev_day, n3_next_year,
                              n3_next_month, n3_next_day, r_s2_len, r_s2_quarter};
            end else begin
                r_s3_data <= 56'd0;
            end
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = r_s3_data;
    assign m_axis_tuser  = r_s3_valid_res;

    // Checks on the pipeline and the result masking.
    `GDSC_ASSERT_SAME(a_invalid_zero, r_v3 && !r_s3_valid_res, r_s3_data == 56'd0)
    `GDSC_ASSERT_SAME(a_valid_len, r_v3 && r_s3_valid_res, r_s3_data[7:3] >= gdsc_pkg::DAYS_28)
    `GDSC_ASSERT_NEXT(a_accept_fills, s_axis_tvalid && s_axis_tready, r_v1)
    `GDSC_ASSERT_NEXT(a_stage1_holds, r_v1 && !rdy2, r_v1 && $stable(r_s1_year))

endmodule

// File: test/testbench.sv
// Testbench for gregorian_date_step_and_check: walks a short table of dates, then random dates.
// Results are checked against typed rows or a calendar predictor; month codes from gdsc_pkg.
// Stand-alone; needs only the RTL files of the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_DATES     = 1700;
    localparam int QUIET_TAIL_DATES = 200;
    localparam int PAUSE_AT         = 900;
    localparam int LONG_HOLD_AT     = 500;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int SETTLE_CYCLES    = 12;
    localparam int MAX_REPORTS      = 10;
    localparam int NUM_ROWS         = 25;

    // One result item, fields named as on the output side.
    typedef struct packed {
        logic        valid_res;
        logic [2:0]  quarter;
        logic [4:0]  month_days;
        logic [4:0]  next_day;
        logic [3:0]  next_month;
        logic [13:0] next_year;
        logic [4:0]  prev_day;
        logic [3:0]  prev_month;
        logic [14:0] prev_year;
    } t_date_step;

    // One directed row: a date and, where it is obvious, its result typed in.
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        typed;
        t_date_step  res;
    } t_date_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // day[4:0], month[8:5], year[22:9], zero[23]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // quarter[2:0], month_days[7:3], next_day[12:8], next_month[16:13],
    // next_year[30:17], prev_day[35:31], prev_month[39:36], prev_year[54:40], zero[55]
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;        // valid_res[0]

    // Typed expectation that travels alongside the date item being offered.
    logic        typed_valid = 1'b0;
    t_date_step  typed_res = '0;

    t_date_step  expected_steps[$];
    t_date_row   date_table [NUM_ROWS];
    int          accepted_dates = 0;
    int          valid_dates = 0;
    int          checked_steps = 0;
    int          mismatches = 0;
    bit          quiet_tail = 1'b0;
    bit          long_hold_active = 1'b0;
    bit          long_hold_done = 1'b0;

    gregorian_date_step_and_check i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // Leap year by the 4/100/400 rule.
    function automatic bit leap_year(input logic [13:0] y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Length of a month 1 to 12 in a given year.
    function automatic logic [4:0] month_length(input logic [3:0] m, input logic [13:0] y);
        logic [4:0] len;
        case (m)
            gdsc_pkg::M_APR, gdsc_pkg::M_JUN,
            gdsc_pkg::M_SEP, gdsc_pkg::M_NOV: len = 5'd30;
            gdsc_pkg::M_FEB:                  len = leap_year(y) ? 5'd29 : 5'd28;
            default:                          len = 5'd31;
        endcase
        return len;
    endfunction

    // Calendar predictor: validity, quarter, month length, following and preceding date.
    function automatic t_date_step step_date(input logic [4:0] d, input logic [3:0] m,
                                             input logic [13:0] y);
        t_date_step r;
        logic [4:0] len;
        r = '0;
        if (d == 5'd0 || m < gdsc_pkg::M_JAN || m > gdsc_pkg::M_DEC || y > gdsc_pkg::YEAR_MAX)
            return r;
        len = month_length(m, y);
        if (d > len)
            return r;
        r.valid_res  = 1'b1;
        r.quarter    = 3'((int'(m) - 1) / 3 + 1);
        r.month_days = len;
        // Following date.
        if (d < len) begin
            r.next_day = d + 5'd1; r.next_month = m; r.next_year = y;
        end else if (m == gdsc_pkg::M_DEC) begin
            r.next_day = 5'd1; r.next_month = gdsc_pkg::M_JAN; r.next_year = y + 14'd1;
        end else begin
            r.next_day = 5'd1; r.next_month = m + 4'd1; r.next_year = y;
        end
        // Preceding date; a month start borrows the length of the month before.
        if (d > 5'd1) begin
            r.prev_day = d - 5'd1; r.prev_month = m; r.prev_year = {1'b0, y};
        end else if (m == gdsc_pkg::M_JAN) begin
            r.prev_day   = 5'd31;
            r.prev_month = gdsc_pkg::M_DEC;
            r.prev_year  = 15'(int'(y) - 1);
        end else begin
            r.prev_day   = month_length(m - 4'd1, y);
            r.prev_month = m - 4'd1;
            r.prev_year  = {1'b0, y};
        end
        return r;
    endfunction

    function automatic t_date_row date_row(input logic [4:0] d, input logic [3:0] m,
                                           input logic [13:0] y, input logic typed,
                                           input t_date_step res);
        t_date_row row;
        row.day = d; row.month = m; row.year = y; row.typed = typed; row.res = res;
        return row;
    endfunction

    // Offer one date; returns after the edge at which it was accepted.
    task automatic offer_date(input logic [4:0] d, input logic [3:0] m, input logic [13:0] y,
                              input logic typed, input t_date_step res);
        int gap;
        if (!quiet_tail && !long_hold_active && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, y, m, d};
        typed_valid   <= typed;
        typed_res     <= res;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Random date: mostly well-formed with edge-heavy content, the rest noise or broken dates.
    task automatic offer_random_date();
        logic [4:0]  d;
        logic [3:0]  m;
        logic [13:0] y;
        logic [4:0]  len;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            m = 4'($urandom_range(int'(gdsc_pkg::M_JAN), int'(gdsc_pkg::M_DEC)));
            case ($urandom_range(0, 7))
                0:       y = 14'($urandom_range(0, 24) * 400);
                1:       y = 14'($urandom_range(0, 99) * 100);
                2:       y = 14'($urandom_range(0, 2499) * 4);
                3:       y = ($urandom_range(0, 1) == 0) ? 14'd0 : gdsc_pkg::YEAR_MAX;
                default: y = 14'($urandom_range(0, 9999));
            endcase
            len = month_length(m, y);
            case ($urandom_range(0, 3))
                0:       d = 5'd1;
                1:       d = len;
                default: d = 5'($urandom_range(1, int'(len)));
            endcase
        end else if (pick < 85) begin
            // Broken: day past month end or year out of range.
            m   = 4'($urandom_range(int'(gdsc_pkg::M_JAN), int'(gdsc_pkg::M_DEC)));
            y   = 14'($urandom_range(0, 9999));
            len = month_length(m, y);
            if (len < 5'd31 && $urandom_range(0, 1) == 0) begin
                d = 5'($urandom_range(int'(len) + 1, 31));
            end else begin
                d = 5'($urandom_range(1, 31));
                y = 14'($urandom_range(10000, 16383));
            end
        end else begin
            d = 5'($urandom_range(0, 31));
            m = 4'($urandom_range(0, 15));
            y = 14'($urandom_range(0, 16383));
        end
        offer_date(d, m, y, 1'b0, '0);
    endtask

    // Result side: random stall bursts, one long hold, none in the final stretch.
    initial begin : result_sink
        int stall_left;
        int k;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && accepted_dates >= LONG_HOLD_AT) begin
                long_hold_active = 1'b1;
                m_axis_tready <= 1'b0;
                for (k = 0; k < LONG_HOLD_CYCLES; k++) @(posedge i_clk);
                long_hold_active = 1'b0;
                long_hold_done   = 1'b1;
            end
            if (quiet_tail) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(0, 15);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Record accepted dates and check every result against the oldest expectation.
    always @(posedge i_clk) begin
        t_date_step got;
        t_date_step want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.valid_res  = m_axis_tuser;
                got.quarter    = m_axis_tdata[2:0];
                got.month_days = m_axis_tdata[7:3];
                got.next_day   = m_axis_tdata[12:8];
                got.next_month = m_axis_tdata[16:13];
                got.next_year  = m_axis_tdata[30:17];
                got.prev_day   = m_axis_tdata[35:31];
                got.prev_month = m_axis_tdata[39:36];
                got.prev_year  = m_axis_tdata[54:40];
                if (expected_steps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: result item with no date pending, got %h",
                                 m_axis_tdata);
                end else begin
                    want = expected_steps.pop_front();
                    checked_steps++;
                    if (got.valid_res != want.valid_res || got.quarter != want.quarter ||
                        got.month_days != want.month_days ||
                        got.next_day != want.next_day || got.next_month != want.next_month ||
                        got.next_year != want.next_year || got.prev_day != want.prev_day ||
                        got.prev_month != want.prev_month ||
                        got.prev_year != want.prev_year) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display({"ERROR: result %0d: expected v%0d q%0d len%0d ",
                                      "next %0d/%0d/%0d prev %0d/%0d/%0h"},
                                     checked_steps, want.valid_res, want.quarter,
                                     want.month_days, want.next_day, want.next_month,
                                     want.next_year, want.prev_day, want.prev_month,
                                     want.prev_year);
                            $display({"       got      v%0d q%0d len%0d ",
                                      "next %0d/%0d/%0d prev %0d/%0d/%0h"},
                                     got.valid_res, got.quarter, got.month_days,
                                     got.next_day, got.next_month, got.next_year,
                                     got.prev_day, got.prev_month, got.prev_year);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                want = typed_valid ? typed_res
                                   : step_date(s_axis_tdata[4:0], s_axis_tdata[8:5],
                                               s_axis_tdata[22:9]);
                if (want.valid_res)
                    valid_dates++;
                expected_steps.push_back(want);
                accepted_dates++;
            end
        end
    end

    // Safety limit on the whole run.
    initial begin
        #10ms;
        $display("Verification failed");
        $finish;
    end

    // Stimulus: directed table, then random dates, then drain and verdict.
    initial begin
        int i;
        int waited;
        date_table = '{
            date_row(5'd0,  gdsc_pkg::M_JAN, 14'd2000,  1'b1, '0),
            date_row(5'd1,  4'd0,            14'd2000,  1'b1, '0),
            date_row(5'd1,  4'd13,           14'd2000,  1'b1, '0),
            date_row(5'd31, 4'd15,           14'd9999,  1'b1, '0),
            date_row(5'd1,  gdsc_pkg::M_JAN, 14'd10000, 1'b1, '0),
            date_row(5'd1,  gdsc_pkg::M_JAN, 14'd16383, 1'b1, '0),
            date_row(5'd30, gdsc_pkg::M_FEB, 14'd2000,  1'b1, '0),
            date_row(5'd29, gdsc_pkg::M_FEB, 14'd1900,  1'b1, '0),
            date_row(5'd31, gdsc_pkg::M_APR, 14'd2021,  1'b1, '0),
            // First day of year zero steps back into year minus one.
            date_row(5'd1,  gdsc_pkg::M_JAN, 14'd0,     1'b1,
                     '{1'b1, 3'd1, 5'd31, 5'd2, gdsc_pkg::M_JAN, 14'd0,
                       5'd31, gdsc_pkg::M_DEC, 15'h7FFF}),
            // Last day of the last year steps forward into year 10000.
            date_row(5'd31, gdsc_pkg::M_DEC, 14'd9999,  1'b1,
                     '{1'b1, 3'd4, 5'd31, 5'd1, gdsc_pkg::M_JAN, 14'd10000,
                       5'd30, gdsc_pkg::M_DEC, 15'd9999}),
            date_row(5'd29, gdsc_pkg::M_FEB, 14'd2000,  1'b0, '0),
            date_row(5'd29, gdsc_pkg::M_FEB, 14'd2024,  1'b0, '0),
            date_row(5'd28, gdsc_pkg::M_FEB, 14'd2023,  1'b0, '0),
            date_row(5'd1,  gdsc_pkg::M_MAR, 14'd2023,  1'b0, '0),
            date_row(5'd1,  gdsc_pkg::M_MAR, 14'd2024,  1'b0, '0),
            date_row(5'd1,  gdsc_pkg::M_MAY, 14'd2021,  1'b0, '0),
            date_row(5'd1,  gdsc_pkg::M_AUG, 14'd2021,  1'b0, '0),
            date_row(5'd30, gdsc_pkg::M_JUN, 14'd2021,  1'b0, '0),
            date_row(5'd15, gdsc_pkg::M_JUL, 14'd1234,  1'b0, '0),
            date_row(5'd1,  gdsc_pkg::M_OCT, 14'd400,   1'b0, '0),
            date_row(5'd31, gdsc_pkg::M_JAN, 14'd0,     1'b0, '0),
            date_row(5'd29, gdsc_pkg::M_FEB, 14'd0,     1'b0, '0),
            date_row(5'd1,  gdsc_pkg::M_MAR, 14'd1900,  1'b0, '0),
            date_row(5'd30, gdsc_pkg::M_NOV, 14'd5678,  1'b0, '0)
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < NUM_ROWS; i++)
            offer_date(date_table[i].day, date_table[i].month, date_table[i].year,
                       date_table[i].typed, date_table[i].res);

        for (i = 0; i < RANDOM_DATES; i++) begin
            if (i == PAUSE_AT) begin
                // Let the block run dry before going on.
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (expected_steps.size() != 0);
            end
            if (i == RANDOM_DATES - QUIET_TAIL_DATES)
                quiet_tail = 1'b1;
            offer_random_date();
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow the pipeline latency to show any stray result.
        waited = 0;
        while (expected_steps.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_steps.size() != 0) begin
            mismatches++;
            $display("ERROR: %0d results never arrived", expected_steps.size());
        end

        $display("Checked %0d results for %0d dates (%0d valid, %0d invalid).",
                 checked_steps, accepted_dates, valid_dates, accepted_dates - valid_dates);
        $display({"Run used random idling on both sides, one long output stall ",
                  "and one drain pause; %0d mismatches."}, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
